>>> hw/rtl/mimo_pkg.sv
package mimo_pkg;

   localparam int SampleW = 16;
   localparam int CoefW   = 16;
   localparam int TapCntW = 7;
   localparam int LinkW   = 2;
   localparam int DelayW  = 6;
   localparam int MaxTaps = 64;

   localparam logic CmdWrite  = 1'b0;
   localparam logic CmdSample = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic cmd;
      logic symbol_start;
      logic signed [SampleW-1:0] tx0_re;
      logic signed [SampleW-1:0] tx0_im;
      logic signed [SampleW-1:0] tx1_re;
      logic signed [SampleW-1:0] tx1_im;
      logic [LinkW-1:0] coef_link;
      logic [DelayW-1:0] coef_delay;
      logic signed [CoefW-1:0] coef_re;
      logic signed [CoefW-1:0] coef_im;
   } req_type;

   typedef struct packed {
      logic signed [SampleW-1:0] rx0_re;
      logic signed [SampleW-1:0] rx0_im;
      logic signed [SampleW-1:0] rx1_re;
      logic signed [SampleW-1:0] rx1_im;
      logic saturated;
   } rsp_type;

   // Control from the sequencer to the lanes.
   typedef struct packed {
      logic clear;
      logic valid;
   } lane_ctl_type;

endpackage

>>> hw/rtl/mimo_req_if.sv
interface mimo_req_if import mimo_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/mimo_rsp_if.sv
interface mimo_rsp_if import mimo_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/mimo_lane.sv
// One receive branch: a complex multiply-accumulate over both transmit
// branches, one delay per cycle. Product is registered before accumulation.
module mimo_lane import mimo_pkg::*; #(
   parameter int AccW = 48
) (
   input  logic                      clock,
   input  lane_ctl_type              ctl,
   input  logic signed [SampleW-1:0] x0_re,
   input  logic signed [SampleW-1:0] x0_im,
   input  logic signed [SampleW-1:0] x1_re,
   input  logic signed [SampleW-1:0] x1_im,
   input  logic signed [CoefW-1:0]   c0_re,
   input  logic signed [CoefW-1:0]   c0_im,
   input  logic signed [CoefW-1:0]   c1_re,
   input  logic signed [CoefW-1:0]   c1_im,
   output logic signed [AccW-1:0]    acc_re,
   output logic signed [AccW-1:0]    acc_im
);
   localparam int PW = SampleW + CoefW + 2;

   logic signed [PW-1:0]   pre_ff, pim_ff, pre_in, pim_in;
   logic                   pv_ff;
   logic signed [AccW-1:0] are_ff, aim_ff;

   always_comb begin
      pre_in = PW'(x0_re * c0_re) - PW'(x0_im * c0_im)
             + PW'(x1_re * c1_re) - PW'(x1_im * c1_im);
      pim_in = PW'(x0_re * c0_im) + PW'(x0_im * c0_re)
             + PW'(x1_re * c1_im) + PW'(x1_im * c1_re);
   end

   always_ff @(posedge clock) begin
      pre_ff <= pre_in;
      pim_ff <= pim_in;
      pv_ff  <= ctl.valid;
      if (ctl.clear) begin
         are_ff <= '0;
         aim_ff <= '0;
      end else if (pv_ff) begin
         are_ff <= are_ff + AccW'(pre_ff);
         aim_ff <= aim_ff + AccW'(pim_ff);
      end
   end

   assign acc_re = are_ff;
   assign acc_im = aim_ff;
endmodule

>>> hw/rtl/mimo_merge.sv
// Rounds the lane sums to sample scale and saturates.
module mimo_merge import mimo_pkg::*; #(
   parameter int AccW = 48
) (
   input  logic signed [AccW-1:0] r0_re,
   input  logic signed [AccW-1:0] r0_im,
   input  logic signed [AccW-1:0] r1_re,
   input  logic signed [AccW-1:0] r1_im,
   output rsp_type                rsp
);
   localparam int S = CoefW - 1;
   localparam logic signed [AccW-1:0] MaxV = AccW'((64'sd1 <<< (SampleW - 1)) - 1);
   localparam logic signed [AccW-1:0] MinV = -MaxV - AccW'(1);

   function automatic logic [SampleW:0] fin(input logic signed [AccW-1:0] a);
      logic signed [AccW-1:0] v;
      logic signed [AccW-1:0] q;
      v = a + AccW'(64'sd1 <<< (S - 1));
      q = v >>> S;
      if (q > MaxV)      fin = {1'b1, MaxV[SampleW-1:0]};
      else if (q < MinV) fin = {1'b1, MinV[SampleW-1:0]};
      else               fin = {1'b0, q[SampleW-1:0]};
   endfunction

   logic [SampleW:0] a, b, c, d;
   always_comb begin
      a = fin(r0_re);
      b = fin(r0_im);
      c = fin(r1_re);
      d = fin(r1_im);
      rsp.rx0_re    = a[SampleW-1:0];
      rsp.rx0_im    = b[SampleW-1:0];
      rsp.rx1_re    = c[SampleW-1:0];
      rsp.rx1_im    = d[SampleW-1:0];
      rsp.saturated = a[SampleW] | b[SampleW] | c[SampleW] | d[SampleW];
   end
endmodule

>>> hw/rtl/mimo_2x2_fir_channel_core.sv
// Channel  Direction  Contents
// req      in         coefficient write or one sample per transmit branch
// rsp      out        one sample per receive branch and saturation flag
// csr      in         tap_count write
//
// A write item leaves the block ready. For a sample item let n = min(tap_count, samples
// since start + 1, MaxTaps): two lanes, one per receive branch, take delays 0 to n - 1,
// one delay a cycle, from the coefficient memory and history, then the read, product
// and accumulate registers drain, and the result is offered until it is taken.
// No new item is taken until the result has been taken.
// Reset is synchronous; the history is not cleared, since delays older than
// the symbol start are never read. A stalled result blocks new items.
module mimo_2x2_fir_channel_core import mimo_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   mimo_req_if.sink          req,
   mimo_rsp_if.source        rsp,
   input  logic              csr_write_enable,
   input  logic [TapCntW-1:0] csr_write_data
);
   localparam int AW   = $clog2(MaxTaps) > 0 ? $clog2(MaxTaps) : 1;
   localparam int CW   = $clog2(MaxTaps + 1);
   localparam int AccW = 2 * (SampleW + CoefW) + AW + 2;

   // Coefficient store per link, history as circular buffer per branch.
   logic [2*CoefW-1:0]   cmem0 [MaxTaps];
   logic [2*CoefW-1:0]   cmem1 [MaxTaps];
   logic [2*CoefW-1:0]   cmem2 [MaxTaps];
   logic [2*CoefW-1:0]   cmem3 [MaxTaps];
   logic [2*SampleW-1:0] hmem0 [MaxTaps];
   logic [2*SampleW-1:0] hmem1 [MaxTaps];

   state_type        state_ff, state_in;
   logic [TapCntW-1:0] taps_ff;
   logic [CW-1:0]    since_ff, since_in;
   logic [AW-1:0]    head_ff, head_in;
   logic [CW-1:0]    cnt_ff, cnt_in, n_ff, n_in;
   logic [1:0]       drain_ff, drain_in;
   logic             rd_valid_ff;
   logic [2*CoefW-1:0]   c0_ff, c1_ff, c2_ff, c3_ff;
   logic [2*SampleW-1:0] h0_ff, h1_ff;
   rsp_type          out_ff, merged;
   lane_ctl_type     ctl;
   logic             start;
   logic [AW-1:0]    raddr, haddr;
   logic [CW-1:0]    since_eff, tcap;
   logic signed [AccW-1:0] a0r, a0i, a1r, a1i;

   assign start = req.valid && req.ready && req.data.cmd == CmdSample;
   assign raddr = cnt_ff[AW-1:0];
   assign haddr = head_ff - cnt_ff[AW-1:0];
   assign req.ready = state_ff == ST_IDLE;
   assign rsp.valid = state_ff == ST_HOLD;
   assign rsp.data  = out_ff;

   always_comb begin
      since_eff = req.data.symbol_start ? '0 : since_ff;
      tcap = (taps_ff > TapCntW'(MaxTaps)) ? CW'(MaxTaps) : CW'(taps_ff);
   end

   always_comb begin
      state_in = state_ff;
      since_in = since_ff;
      head_in  = head_ff;
      cnt_in   = cnt_ff;
      n_in     = n_ff;
      drain_in = drain_ff;
      ctl      = '{clear: 1'b0, valid: rd_valid_ff};
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               head_in  = head_ff + AW'(1);
               n_in     = (since_eff + CW'(1) < tcap) ? since_eff + CW'(1) : tcap;
               since_in = (since_eff < CW'(MaxTaps)) ? since_eff + CW'(1) : since_eff;
               cnt_in   = '0;
               ctl.clear = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (cnt_ff + CW'(1) >= n_ff || n_ff == '0) begin
               drain_in = 2'd3;
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff - 2'd1;
            if (drain_ff == 2'd1) state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (rsp.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         taps_ff     <= TapCntW'(1);
         since_ff    <= '0;
         head_ff     <= '0;
         cnt_ff      <= '0;
         n_ff        <= '0;
         drain_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         since_ff    <= since_in;
         head_ff     <= head_in;
         cnt_ff      <= cnt_in;
         n_ff        <= n_in;
         drain_ff    <= drain_in;
         rd_valid_ff <= state_ff == ST_RUN && n_ff != '0;
         if (csr_write_enable) taps_ff <= csr_write_data;
      end
   end

   // Memories: writes on accepted items, registered reads.
   always_ff @(posedge clock) begin
      if (req.valid && req.ready && req.data.cmd == CmdWrite &&
          {1'b0, req.data.coef_delay} < (DelayW+1)'(MaxTaps)) begin
         case (req.data.coef_link)
            2'd0: cmem0[req.data.coef_delay[AW-1:0]] <= {req.data.coef_re, req.data.coef_im};
            2'd1: cmem1[req.data.coef_delay[AW-1:0]] <= {req.data.coef_re, req.data.coef_im};
            2'd2: cmem2[req.data.coef_delay[AW-1:0]] <= {req.data.coef_re, req.data.coef_im};
            default: cmem3[req.data.coef_delay[AW-1:0]] <= {req.data.coef_re, req.data.coef_im};
         endcase
      end
      if (start) begin
         hmem0[head_ff + AW'(1)] <= {req.data.tx0_re, req.data.tx0_im};
         hmem1[head_ff + AW'(1)] <= {req.data.tx1_re, req.data.tx1_im};
      end
      c0_ff <= cmem0[raddr];
      c1_ff <= cmem1[raddr];
      c2_ff <= cmem2[raddr];
      c3_ff <= cmem3[raddr];
      h0_ff <= hmem0[haddr];
      h1_ff <= hmem1[haddr];
   end

   mimo_lane #(.AccW(AccW)) u_lane0 (
      .clock, .ctl,
      .x0_re(h0_ff[2*SampleW-1:SampleW]), .x0_im(h0_ff[SampleW-1:0]),
      .x1_re(h1_ff[2*SampleW-1:SampleW]), .x1_im(h1_ff[SampleW-1:0]),
      .c0_re(c0_ff[2*CoefW-1:CoefW]), .c0_im(c0_ff[CoefW-1:0]),
      .c1_re(c1_ff[2*CoefW-1:CoefW]), .c1_im(c1_ff[CoefW-1:0]),
      .acc_re(a0r), .acc_im(a0i));

   mimo_lane #(.AccW(AccW)) u_lane1 (
      .clock, .ctl,
      .x0_re(h0_ff[2*SampleW-1:SampleW]), .x0_im(h0_ff[SampleW-1:0]),
      .x1_re(h1_ff[2*SampleW-1:SampleW]), .x1_im(h1_ff[SampleW-1:0]),
      .c0_re(c2_ff[2*CoefW-1:CoefW]), .c0_im(c2_ff[CoefW-1:0]),
      .c1_re(c3_ff[2*CoefW-1:CoefW]), .c1_im(c3_ff[CoefW-1:0]),
      .acc_re(a1r), .acc_im(a1i));

   mimo_merge #(.AccW(AccW)) u_merge (
      .r0_re(a0r), .r0_im(a0i), .r1_re(a1r), .r1_im(a1i), .rsp(merged));

   always_ff @(posedge clock) begin
      if (state_ff == ST_DRAIN && drain_ff == 2'd1) out_ff <= merged;
   end
endmodule

>>> hw/rtl/mimo_core_checker.sv
module mimo_core_checker import mimo_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    req_cmd,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);
   // A result waiting to be taken keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // No new item is taken while a result is pending.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("item accepted with result pending");

   // A sample item gives no result in the very next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd == CmdSample |=> !rsp_valid)
      else $error("result too early");

   // A write item leaves the block ready.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd == CmdWrite |=> req_ready)
      else $error("write item stalled the block");
endmodule

bind mimo_2x2_fir_channel_core mimo_core_checker u_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready), .req_cmd(req.data.cmd),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data));

>>> bench/mimo_2x2_fir_channel_core_tb.sv
module mimo_2x2_fir_channel_core_tb;
   import mimo_pkg::*;

   localparam int Taps = MaxTaps;
   localparam int SettleCycles = 80;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [TapCntW-1:0] csr_write_data;

   mimo_req_if req_ch ();
   mimo_rsp_if rsp_ch ();

   mimo_2x2_fir_channel_core dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Own copy of the channel state.
   logic signed [CoefW-1:0]   coef_re_mem [4][Taps];
   logic signed [CoefW-1:0]   coef_im_mem [4][Taps];
   logic signed [SampleW-1:0] hist_re [2][Taps];
   logic signed [SampleW-1:0] hist_im [2][Taps];
   int unsigned since_start;
   int unsigned tap_setting;

   rsp_type rx_expected_q [$];
   int mismatches;
   int samples_sent;
   int writes_sent;
   int rx_checked;
   int sat_seen;
   bit idle_on;
   int hold_len;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic logic signed [SampleW-1:0] round_sat(input longint acc, inout bit sat);
      longint q;
      q = (acc + 64'sd16384) >>> 15;
      if (q > 32767) begin
         sat = 1'b1;
         q = 32767;
      end
      if (q < -32768) begin
         sat = 1'b1;
         q = -32768;
      end
      return q[SampleW-1:0];
   endfunction

   // Updates the channel state for one accepted item and queues the result of a sample item.
   function automatic void model_channel(input req_type it);
      longint acc_re [2];
      longint acc_im [2];
      int unsigned taps;
      bit sat;
      rsp_type r;
      if (it.cmd == CmdWrite) begin
         coef_re_mem[it.coef_link][it.coef_delay] = it.coef_re;
         coef_im_mem[it.coef_link][it.coef_delay] = it.coef_im;
         return;
      end
      if (it.symbol_start) since_start = 0;
      for (int d = Taps - 1; d > 0; d--) begin
         for (int t = 0; t < 2; t++) begin
            hist_re[t][d] = hist_re[t][d-1];
            hist_im[t][d] = hist_im[t][d-1];
         end
      end
      hist_re[0][0] = it.tx0_re;
      hist_im[0][0] = it.tx0_im;
      hist_re[1][0] = it.tx1_re;
      hist_im[1][0] = it.tx1_im;
      taps = (tap_setting > Taps) ? Taps : tap_setting;
      for (int rx = 0; rx < 2; rx++) begin
         acc_re[rx] = 0;
         acc_im[rx] = 0;
         for (int tx = 0; tx < 2; tx++) begin
            for (int d = 0; d < taps && d <= since_start; d++) begin
               acc_re[rx] += longint'(hist_re[tx][d]) * coef_re_mem[rx*2+tx][d]
                           - longint'(hist_im[tx][d]) * coef_im_mem[rx*2+tx][d];
               acc_im[rx] += longint'(hist_re[tx][d]) * coef_im_mem[rx*2+tx][d]
                           + longint'(hist_im[tx][d]) * coef_re_mem[rx*2+tx][d];
            end
         end
      end
      if (since_start < Taps) since_start++;
      sat = 1'b0;
      r.rx0_re = round_sat(acc_re[0], sat);
      r.rx0_im = round_sat(acc_im[0], sat);
      r.rx1_re = round_sat(acc_re[1], sat);
      r.rx1_im = round_sat(acc_im[1], sat);
      r.saturated = sat;
      rx_expected_q.push_back(r);
   endfunction

   function automatic logic [15:0] rand_word();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($urandom_range(0, 255)) - 16'd128;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type make_write(input int link, input int delay,
                                          input logic [15:0] re, input logic [15:0] im);
      req_type it;
      it = req_type'($urandom);
      it.tx0_re = rand_word();
      it.tx1_im = rand_word();
      it.cmd = CmdWrite;
      it.coef_link = LinkW'(link);
      it.coef_delay = DelayW'(delay);
      it.coef_re = re;
      it.coef_im = im;
      return it;
   endfunction

   function automatic req_type make_sample(input bit start, input logic [15:0] t0r,
                                           input logic [15:0] t0i, input logic [15:0] t1r,
                                           input logic [15:0] t1i);
      req_type it;
      it.coef_link = LinkW'($urandom);
      it.coef_delay = DelayW'($urandom);
      it.coef_re = rand_word();
      it.coef_im = rand_word();
      it.cmd = CmdSample;
      it.symbol_start = start;
      it.tx0_re = t0r;
      it.tx0_im = t0i;
      it.tx1_re = t1r;
      it.tx1_im = t1i;
      return it;
   endfunction

   task automatic send_item(input req_type it);
      int gap;
      gap = idle_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= it;
      do @(posedge clock); while (!req_ch.ready);
      model_channel(it);
      if (it.cmd == CmdSample) samples_sent++;
      else writes_sent++;
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (rx_expected_q.size() != 0) @(posedge clock);
   endtask

   // Waits until every queued result has been taken, then lets the block settle
   // before touching the register.
   task automatic set_taps(input int unsigned value);
      wait_drained();
      repeat (SettleCycles) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= TapCntW'(value);
      @(posedge clock);
      tap_setting = value;
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_random_sample(input int start_odds);
      send_item(make_sample($urandom_range(0, start_odds) == 0, rand_word(), rand_word(),
                            rand_word(), rand_word()));
   endtask

   task automatic test_fill_coefficients();
      for (int l = 0; l < 4; l++)
         for (int d = 0; d < Taps; d++)
            send_item(make_write(l, d, rand_word(), rand_word()));
   endtask

   task automatic test_extremes();
      for (int l = 0; l < 4; l++) send_item(make_write(l, 0, 16'h8000, 16'h0000));
      send_item(make_sample(1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
      send_item(make_sample(1'b0, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000));
      send_item(make_sample(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      send_item(make_write(1, 0, 16'h7fff, 16'h8000));
      send_item(make_write(3, 0, 16'h0001, 16'hffff));
      send_item(make_sample(1'b0, 16'h0001, 16'hffff, 16'h7fff, 16'h7fff));
      set_taps(Taps);
      send_item(make_sample(1'b1, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000));
      send_item(make_sample(1'b0, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000));
      send_item(make_sample(1'b1, 16'h4000, 16'hc000, 16'h0001, 16'h0000));
      set_taps(0);
      send_item(make_sample(1'b0, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000));
      set_taps(127);
      send_item(make_sample(1'b0, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
      send_item(make_sample(1'b1, 16'h1234, 16'hedcb, 16'h8000, 16'h7fff));
   endtask

   task automatic test_random_phase(input int unsigned taps, input int count);
      set_taps(taps);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 6) == 0)
            send_item(make_write($urandom_range(0, 3), $urandom_range(0, Taps - 1),
                                 rand_word(), rand_word()));
         else
            send_random_sample(24);
      end
   endtask

   task automatic test_backpressure();
      set_taps(8);
      hold_len = 300;
      for (int i = 0; i < 30; i++) send_random_sample(10);
      wait_drained();
      for (int i = 0; i < 10; i++) send_random_sample(10);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (rx_expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", rsp_ch.data);
         end else begin
            rsp_type want;
            want = rx_expected_q.pop_front();
            rx_checked++;
            if (want.saturated) sat_seen++;
            if (rsp_ch.data.rx0_re !== want.rx0_re || rsp_ch.data.rx0_im !== want.rx0_im ||
                rsp_ch.data.rx1_re !== want.rx1_re || rsp_ch.data.rx1_im !== want.rx1_im ||
                rsp_ch.data.saturated !== want.saturated) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d mismatch: expected %p, got %p",
                           rx_checked, want, rsp_ch.data);
            end
         end
      end
   end

   // Receiver: random stalls per item, plus one long hold when requested.
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = idle_on ? $urandom_range(0, 4) : 0;
         if (hold_len > 0) begin
            stall = hold_len;
            hold_len = 0;
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   initial begin
      int wait_cycles;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data <= '0;
      idle_on = 1'b1;
      hold_len = 0;
      since_start = 0;
      tap_setting = 1;
      for (int t = 0; t < 2; t++)
         for (int d = 0; d < Taps; d++) begin
            hist_re[t][d] = '0;
            hist_im[t][d] = '0;
         end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_fill_coefficients();
      test_extremes();
      test_random_phase(1, 30);
      test_random_phase(64, 40);
      idle_on = 1'b0;
      test_random_phase($urandom_range(2, 63), 30);
      idle_on = 1'b1;
      test_random_phase(0, 15);
      test_random_phase(127, 30);
      test_random_phase($urandom_range(2, 16), 30);
      test_backpressure();
      test_random_phase($urandom_range(17, 63), 30);

      req_ch.valid <= 1'b0;
      wait_cycles = 0;
      while (rx_expected_q.size() != 0 && wait_cycles < 100_000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (SettleCycles) @(posedge clock);
      if (rx_expected_q.size() != 0) mismatches += rx_expected_q.size();

      $display("Sent %0d sample items and %0d coefficient writes; %0d results checked.",
               samples_sent, writes_sent, rx_checked);
      $display("Tap counts 0, 1, 64, 127 and random ones; %0d saturated results; %0d mismatches.",
               sat_seen, mismatches);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
